FILE: sv/pu_pkg.sv
// Shared constants, factorial table and controller/datapath interface types.
package pu_pkg;

    // Sizing
    localparam int MAX_NODES   = 12;
    localparam int RANK_W      = 29;
    localparam int NODE_W      = 4;
    localparam int CFG_W       = 4;
    localparam int CFG_RESET   = 4;
    localparam int FACT_W      = 64;  // holds factorials up to 20!
    localparam int CNT_W       = $clog2(MAX_NODES + 1);
    localparam int QW          = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int BW          = (QW > 1) ? $clog2(QW) : 1;
    localparam int TDATA_IN_W  = ((RANK_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((NODE_W + 7) / 8) * 8;

    // Factorial table, built at elaboration: FACT_TAB[i] = i!
    typedef logic [FACT_W-1:0] t_fact_tab [0:MAX_NODES];

    function automatic t_fact_tab fact_tab_f();
        t_fact_tab t;
        t[0] = FACT_W'(1);
        for (int i = 1; i <= MAX_NODES; i++) begin
            t[i] = t[i-1] * FACT_W'(i);
        end
        return t;
    endfunction

    localparam t_fact_tab FACT_TAB = fact_tab_f();

    // What goes into the output register on a push
    typedef enum logic [1:0] {
        PUSH_HEAD,
        PUSH_NODE,
        PUSH_TAIL,
        PUSH_BAD
    } t_push;

    // Controller -> datapath
    typedef struct packed {
        logic  load;      // capture rank, node count and fresh pool
        logic  push;      // write output register
        t_push push_sel;
        logic  div_init;  // clear quotient, start at top bit
        logic  div_step;  // one restoring division step
        logic  remove;    // drop selected node from the pool
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;   // output register empty or being drained
        logic bad;        // captured rank is out of range
        logic cnt_zero;
        logic cnt_one;
        logic bit_zero;   // last division step
    } t_stat;

endpackage

FILE: sv/permutation_unrank_top.sv
// Top level of the factorial-base permutation unranking block.
//
//  channel   direction  payload (low bit up)            framing
//  -------   ---------  ------------------------------  -----------------------------
//  s_axis    in         tdata: rank[28:0], zero pad     one request per rank
//  m_axis    out        tdata: node[3:0], zero pad      0, p1..pn, 0; tlast on final
//                       tuser: bad_rank                 single result when rank bad
//  cfg       in         wdata: node_count[3:0]          write when i_cfg_wen high
//
// Each node digit has QW = 4 quotient bits. The digit divider is restoring,
// one quotient bit per cycle, and each digit is followed by an emit state that
// waits for a free output register.
// A new request is taken once the tail or bad-rank result is in the output register.
// Synchronous active-low reset sets node_count to 4 and empties the output.
// A stalled output holds the sequencer only in a pushing state: head, emit or tail.
module permutation_unrank_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wen,
    input  logic [pu_pkg::CFG_W-1:0]       i_cfg_wdata,   // node_count
    // rank requests
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pu_pkg::TDATA_IN_W-1:0]  i_s_tdata,     // rank
    // permutation results
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pu_pkg::TDATA_OUT_W-1:0] o_m_tdata,     // node
    output logic                           o_m_tlast,
    output logic [0:0]                     o_m_tuser      // bad_rank
);

    pu_pkg::t_cmd              w_cmd;
    pu_pkg::t_stat             w_stat;
    logic [pu_pkg::NODE_W-1:0] w_node;
    logic                      w_bad;

    pu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rank      (i_s_tdata[pu_pkg::RANK_W-1:0]),
        .i_m_tready  (i_m_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_valid     (o_m_tvalid),
        .o_node      (w_node),
        .o_last      (o_m_tlast),
        .o_bad       (w_bad)
    );

    assign o_m_tdata    = pu_pkg::TDATA_OUT_W'(w_node);
    assign o_m_tuser[0] = w_bad;

`ifndef ASSERT_OFF
    // An accepted request keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after accepting a rank");

    // A rejected rank is a lone depot result that closes the run
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tlast && w_node == '0))
        else $error("bad rank result not a final depot result");

    // Emitted nodes never exceed the pool size
    a_node_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (int'(w_node) <= pu_pkg::MAX_NODES))
        else $error("node out of range");
`endif

endmodule

FILE: sv/pu_ctrl.sv
// Sequencer for unranking: frame head, digit divisions, node emits, frame tail, or a lone bad-rank result.
module pu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  pu_pkg::t_stat i_stat,
    output pu_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_EMIT,
        S_TAIL
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    assign o_s_tready = r_ready;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.push_sel = pu_pkg::PUSH_HEAD;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_stat.bad) begin
                        o_cmd.push_sel = pu_pkg::PUSH_BAD;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.push_sel = pu_pkg::PUSH_HEAD;
                        o_cmd.div_init = 1'b1;
                        n_state        = i_stat.cnt_zero ? S_TAIL : S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.bit_zero) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_sel = pu_pkg::PUSH_NODE;
                    o_cmd.remove   = 1'b1;
                    o_cmd.div_init = 1'b1;
                    n_state        = i_stat.cnt_one ? S_TAIL : S_DIV;
                end
            end
            S_TAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_sel = pu_pkg::PUSH_TAIL;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

FILE: sv/pu_dpath.sv
// Datapath: node count register, range check, digit divider, node pool, output register.
module pu_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [pu_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [pu_pkg::RANK_W-1:0]   i_rank,
    input  logic                        i_m_tready,
    input  pu_pkg::t_cmd                i_cmd,
    output pu_pkg::t_stat               o_stat,
    output logic                        o_valid,
    output logic [pu_pkg::NODE_W-1:0]   o_node,
    output logic                        o_last,
    output logic                        o_bad
);

    logic [pu_pkg::CFG_W-1:0]  r_cfg;
    logic [pu_pkg::RANK_W-1:0] r_idx, n_idx;
    logic [pu_pkg::CNT_W-1:0]  r_cnt;
    logic [pu_pkg::QW-1:0]     r_q, n_q;
    logic [pu_pkg::BW-1:0]     r_bit;
    logic [pu_pkg::NODE_W-1:0] r_pool [pu_pkg::MAX_NODES];
    logic                      r_bad;
    logic                      r_valid;
    logic [pu_pkg::NODE_W-1:0] r_node;
    logic                      r_last;
    logic                      r_obad;

    logic [pu_pkg::CNT_W-1:0]  w_n;
    logic                      w_bad;
    logic [pu_pkg::CNT_W-1:0]  w_fidx;
    logic [pu_pkg::FACT_W-1:0] w_fact;
    logic [pu_pkg::RANK_W-1:0] w_shr;
    logic                      w_ge;
    logic                      w_free;
    logic [pu_pkg::NODE_W-1:0] w_sel;

    // Node count, saturated to the pool size
    assign w_n = (int'(r_cfg) > pu_pkg::MAX_NODES) ? pu_pkg::CNT_W'(pu_pkg::MAX_NODES)
                                                   : pu_pkg::CNT_W'(r_cfg);

    // Range check on the incoming one-based rank
    assign w_bad = (i_rank == '0) ||
                   (pu_pkg::FACT_W'(i_rank) > pu_pkg::FACT_TAB[w_n]);

    // Divisor for the current digit is (count-1)!
    assign w_fidx = (r_cnt == '0) ? '0 : r_cnt - pu_pkg::CNT_W'(1);
    assign w_fact = pu_pkg::FACT_TAB[w_fidx];

    // Restoring step: idx >= f << b is tested as (idx >> b) >= f, no overflow
    assign w_shr = r_idx >> r_bit;
    assign w_ge  = pu_pkg::FACT_W'(w_shr) >= w_fact;

    always_comb begin
        n_idx = r_idx;
        n_q   = r_q;
        if (w_ge) begin
            n_idx        = r_idx - pu_pkg::RANK_W'(w_fact << r_bit);
            n_q[r_bit]   = 1'b1;
        end
    end

    assign w_sel  = r_pool[r_q];
    assign w_free = !r_valid || i_m_tready;

    assign o_stat.out_free = w_free;
    assign o_stat.bad      = r_bad;
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.cnt_one  = (r_cnt == pu_pkg::CNT_W'(1));
    assign o_stat.bit_zero = (r_bit == '0);

    // Control registers: configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= pu_pkg::CFG_W'(pu_pkg::CFG_RESET);
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.push) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= i_rank - pu_pkg::RANK_W'(1);
            r_cnt <= w_n;
            r_bad <= w_bad;
            for (int k = 0; k < pu_pkg::MAX_NODES; k++) begin
                r_pool[k] <= pu_pkg::NODE_W'(k + 1);
            end
        end
        if (i_cmd.div_step) begin
            r_idx <= n_idx;
            r_q   <= n_q;
            r_bit <= r_bit - pu_pkg::BW'(1);
        end
        if (i_cmd.div_init) begin
            r_q   <= '0;
            r_bit <= pu_pkg::BW'(pu_pkg::QW - 1);
        end
        // Close the gap left by the chosen node
        if (i_cmd.remove) begin
            r_cnt <= r_cnt - pu_pkg::CNT_W'(1);
            for (int k = 0; k < pu_pkg::MAX_NODES - 1; k++) begin
                if (pu_pkg::QW'(k) >= r_q) begin
                    r_pool[k] <= r_pool[k+1];
                end
            end
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            unique case (i_cmd.push_sel)
                pu_pkg::PUSH_HEAD: begin
                    r_node <= '0;
                    r_last <= 1'b0;
                    r_obad <= 1'b0;
                end
                pu_pkg::PUSH_NODE: begin
                    r_node <= w_sel;
                    r_last <= 1'b0;
                    r_obad <= 1'b0;
                end
                pu_pkg::PUSH_TAIL: begin
                    r_node <= '0;
                    r_last <= 1'b1;
                    r_obad <= 1'b0;
                end
                pu_pkg::PUSH_BAD: begin
                    r_node <= '0;
                    r_last <= 1'b1;
                    r_obad <= 1'b1;
                end
                default: begin
                    r_node <= '0;
                    r_last <= 1'b1;
                    r_obad <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_node  = r_node;
    assign o_last  = r_last;
    assign o_bad   = r_obad;

endmodule
